FILE: rtl/rhd_pkg.sv
// shared types and constants for the rtp h.264 payload depacketizer
// no dependencies
package rhd_pkg;

    localparam int START_CODE_BYTES_DEF = 4;
    localparam int LENGTH_BITS_DEF      = 16;

    localparam logic [16:0] LEN_MAX = 17'h1ffff;

    // nal unit type codes
    localparam logic [4:0] NAL_IDR        = 5'd5;
    localparam logic [4:0] NAL_MAX_SINGLE = 5'd23;
    localparam logic [4:0] NAL_STAP_A     = 5'd24;
    localparam logic [4:0] NAL_FU_A       = 5'd28;
    localparam logic [4:0] NAL_UNDEF_LO   = 5'd30;
    localparam logic [4:0] NAL_UNDEF_HI   = 5'd31;

    localparam logic [7:0] NAL_TYPE_MASK  = 8'h1f;
    localparam logic [7:0] NAL_FNRI_MASK  = 8'he0;
    localparam logic [7:0] FU_END_MASK    = 8'h40;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_SINGLE = 3'd1,
        MODE_FRAG   = 3'd2,
        MODE_AGG    = 3'd3,
        MODE_DROP   = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        PH_LEN_HI   = 2'd0,
        PH_LEN_LO   = 2'd1,
        PH_BODY     = 2'd2,
        PH_DISCARD  = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        OC_SINGLE    = 3'd0,
        OC_FRAGMENT  = 3'd1,
        OC_AGGREGATE = 3'd2,
        OC_UNHANDLED = 3'd3,
        OC_UNDEFINED = 3'd4,
        OC_EMPTY     = 3'd5,
        OC_SHORT_FU  = 3'd6,
        OC_LEN_ERR   = 3'd7
    } outcome_t;

    // held error code: the single code doubles as no error
    localparam outcome_t OC_NONE = OC_SINGLE;

    typedef enum logic {
        KIND_DATA    = 1'b0,
        KIND_SUMMARY = 1'b1
    } kind_t;

endpackage

FILE: rtl/rtp_h264_payload_depacketizer_top.sv
// rtp h.264 payload depacketizer, top level and only module
// depends on rhd_pkg
//
// usage:
//   s_axis carries one rtp payload byte per transfer; tuser flags the first
//   byte of a packet, and on that byte tdata also carries the packet length
//   m_axis carries result transfers: data bytes of the rebuilt h.264 stream
//   (tuser 0) and one summary record per completed packet (tuser 1) after its data;
//   tlast marks the final result caused by one input byte
// path: an accepted byte loads the job register, and its results pass from there
//   through the output register to m_axis
// throughput: one input byte per cycle while each byte gives at most one
//   result and m_axis is not stalled; a byte that gives more results holds
//   the input until its last result leaves the job register, since the single
//   output register drains the job register one item a cycle while m_axis_tready
//   is high (a stap-a length prefix gives the start code, up to
//   START_CODE_BYTES + 1 results with a summary); bytes that give no result never hold the input
// stall: when m_axis_tready is low the output register holds its transfer,
//   the job register keeps its pending results and s_axis_tready drops while any are pending
// reset: rst_n clears packet state to idle and empties both registers
module rtp_h264_payload_depacketizer_top #(
    parameter int START_CODE_BYTES = rhd_pkg::START_CODE_BYTES_DEF,
    parameter int LENGTH_BITS      = rhd_pkg::LENGTH_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] payload_byte, [23:8] packet_length
    input  logic [23:0] s_axis_tdata,
    // [0] first_of_packet
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] data_byte, [10:8] outcome, [11] keyframe, [12] fragment_start,
    // [13] fragment_end, [21:14] rebuilt_header, [38:22] output_length,
    // [39] zero fill
    output logic [39:0] m_axis_tdata,
    // [0] item_kind
    output logic        m_axis_tuser,
    // run_last
    output logic        m_axis_tlast
);
    import rhd_pkg::*;

    // item index counts data items then the summary
    localparam int IDX_W = $clog2(START_CODE_BYTES + 2);
    localparam logic [16:0] SIZE_LIMIT = 17'((1 << LENGTH_BITS) - 1);

    typedef struct packed {
        logic [IDX_W-1:0] n_data;      // data items in this job
        logic             start_code;  // data items are a start code
        logic [7:0]       data_byte;
        logic             has_sum;
        outcome_t         outcome;
        logic             keyframe;
        logic             frag_start;
        logic             frag_end;
        logic [7:0]       header;
        logic [16:0]      out_len;
    } job_t;

    // packet state
    logic [15:0]            bytes_rem_reg,  bytes_rem_next;
    mode_t                  mode_reg,       mode_next;
    phase_t                 phase_reg,      phase_next;
    logic [7:0]             len_hi_reg,     len_hi_next;
    logic [LENGTH_BITS-1:0] nal_left_reg,   nal_left_next;
    logic                   nal_first_reg,  nal_first_next;
    logic [1:0]             hdr_idx_reg,    hdr_idx_next;
    logic                   key_reg,        key_next;
    logic                   sflag_reg,      sflag_next;
    logic                   eflag_reg,      eflag_next;
    logic [7:0]             header_reg,     header_next;
    logic [16:0]            len_cnt_reg,    len_cnt_next;
    outcome_t               err_reg,        err_next;

    // job and output registers
    job_t             job_reg,  job_next;
    logic             job_valid_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             out_valid_reg;
    logic [39:0]      out_data_reg;
    logic             out_user_reg;
    logic             out_last_reg;

    logic             in_acc;
    logic             out_load;
    logic             job_done;
    logic [IDX_W-1:0] job_total;

    logic [7:0]  in_byte;
    logic        in_first;
    logic [15:0] in_len;
    logic [4:0]  unit_type;

    assign in_byte   = s_axis_tdata[7:0];
    assign in_len    = s_axis_tdata[23:8];
    assign in_first  = s_axis_tuser;
    assign unit_type = 5'(in_byte & NAL_TYPE_MASK);

    assign out_load  = !out_valid_reg || m_axis_tready;
    assign job_total = job_reg.n_data + IDX_W'(job_reg.has_sum);
    assign job_done  = job_valid_reg && out_load && (idx_reg == job_total - IDX_W'(1));
    assign s_axis_tready = !job_valid_reg || job_done;
    assign in_acc = s_axis_tvalid && s_axis_tready;

    // per-byte packet processing
    always_comb
    begin
        logic             active;
        logic             empty_pkt;
        logic [15:0]      size;
        logic [15:0]      rest;
        logic [17:0]      len_sum;
        logic [LENGTH_BITS-1:0] left_dec;

        bytes_rem_next = bytes_rem_reg;
        mode_next      = mode_reg;
        phase_next     = phase_reg;
        len_hi_next    = len_hi_reg;
        nal_left_next  = nal_left_reg;
        nal_first_next = nal_first_reg;
        hdr_idx_next   = hdr_idx_reg;
        key_next       = key_reg;
        sflag_next     = sflag_reg;
        eflag_next     = eflag_reg;
        header_next    = header_reg;
        len_cnt_next   = len_cnt_reg;
        err_next       = err_reg;

        job_next            = '0;
        job_next.data_byte  = in_byte;
        job_next.outcome    = OC_SINGLE;
        active    = 1'b0;
        empty_pkt = 1'b0;
        size      = {len_hi_reg, in_byte};
        rest      = bytes_rem_reg - 16'd1;
        left_dec  = '0;

        if (in_first)
        begin
            // a new packet abandons whatever was in progress
            bytes_rem_next = '0;
            mode_next      = MODE_IDLE;
            phase_next     = PH_LEN_HI;
            len_hi_next    = '0;
            nal_left_next  = '0;
            nal_first_next = 1'b0;
            hdr_idx_next   = '0;
            key_next       = 1'b0;
            sflag_next     = 1'b0;
            eflag_next     = 1'b0;
            header_next    = '0;
            len_cnt_next   = '0;
            err_next       = OC_NONE;
            if (in_len == 16'd0)
            begin
                empty_pkt        = 1'b1;
                job_next.has_sum = 1'b1;
                job_next.outcome = OC_EMPTY;
            end
            else
            begin
                active         = 1'b1;
                bytes_rem_next = in_len;
                unique case (unit_type) inside
                    [5'd0 : NAL_MAX_SINGLE]:
                    begin
                        mode_next       = MODE_SINGLE;
                        job_next.n_data = IDX_W'(1);
                        if (unit_type == NAL_IDR)
                            key_next = 1'b1;
                    end
                    NAL_STAP_A:
                    begin
                        mode_next  = MODE_AGG;
                        phase_next = PH_LEN_HI;
                    end
                    NAL_FU_A:
                    begin
                        if (in_len < 16'd3)
                        begin
                            mode_next = MODE_DROP;
                            err_next  = OC_SHORT_FU;
                        end
                        else
                        begin
                            mode_next    = MODE_FRAG;
                            hdr_idx_next = 2'd1;
                            header_next  = in_byte & NAL_FNRI_MASK;
                        end
                    end
                    NAL_UNDEF_LO, NAL_UNDEF_HI:
                    begin
                        mode_next = MODE_DROP;
                        err_next  = OC_UNDEFINED;
                    end
                    default:
                    begin
                        mode_next = MODE_DROP;
                        err_next  = OC_UNHANDLED;
                    end
                endcase
            end
        end
        else if (mode_reg != MODE_IDLE && bytes_rem_reg != 16'd0)
        begin
            active = 1'b1;
            unique case (mode_reg)
                MODE_SINGLE:
                    job_next.n_data = IDX_W'(1);
                MODE_FRAG:
                begin
                    if (hdr_idx_reg == 2'd1)
                    begin
                        // fu header: start, end and original nal type
                        sflag_next   = in_byte[7];
                        eflag_next   = |(in_byte & FU_END_MASK);
                        header_next  = header_reg | {3'b000, unit_type};
                        hdr_idx_next = 2'd2;
                        if (unit_type == NAL_IDR && in_byte[7])
                            key_next = 1'b1;
                    end
                    else
                        job_next.n_data = IDX_W'(1);
                end
                MODE_AGG:
                begin
                    unique case (phase_reg)
                        PH_LEN_HI:
                        begin
                            // too few bytes left for a length prefix and at least one body byte
                            if (bytes_rem_reg <= 16'd2)
                                phase_next = PH_DISCARD;
                            else
                            begin
                                len_hi_next = in_byte;
                                phase_next  = PH_LEN_LO;
                            end
                        end
                        PH_LEN_LO:
                        begin
                            if ({1'b0, size} > SIZE_LIMIT || size > rest)
                            begin
                                err_next   = OC_LEN_ERR;
                                phase_next = PH_DISCARD;
                            end
                            else
                            begin
                                job_next.n_data     = IDX_W'(START_CODE_BYTES);
                                job_next.start_code = 1'b1;
                                if (size == 16'd0)
                                    phase_next = PH_LEN_HI;
                                else
                                begin
                                    nal_left_next  = size[LENGTH_BITS-1:0];
                                    nal_first_next = 1'b1;
                                    phase_next     = PH_BODY;
                                end
                            end
                        end
                        PH_BODY:
                        begin
                            job_next.n_data = IDX_W'(1);
                            if (nal_first_reg && unit_type == NAL_IDR)
                                key_next = 1'b1;
                            nal_first_next = 1'b0;
                            left_dec = nal_left_reg;
                            if (nal_left_reg != '0)
                                left_dec = nal_left_reg - LENGTH_BITS'(1);
                            nal_left_next = left_dec;
                            if (left_dec == '0)
                                phase_next = PH_LEN_HI;
                        end
                        default:
                            phase_next = phase_reg;
                    endcase
                end
                default:
                    mode_next = mode_reg;
            endcase
        end

        // saturating count of data bytes emitted
        len_sum = {1'b0, len_cnt_next} + 18'(job_next.n_data);
        if (len_sum > {1'b0, LEN_MAX})
            len_cnt_next = LEN_MAX;
        else
            len_cnt_next = len_sum[16:0];

        if (active)
        begin
            bytes_rem_next = bytes_rem_next - 16'd1;
            if (bytes_rem_next == 16'd0)
            begin
                job_next.has_sum    = 1'b1;
                job_next.keyframe   = key_next;
                job_next.frag_start = sflag_next;
                job_next.frag_end   = eflag_next;
                job_next.header     = header_next;
                job_next.out_len    = len_cnt_next;
                if (err_next != OC_NONE)
                    job_next.outcome = err_next;
                else if (mode_next == MODE_FRAG)
                    job_next.outcome = OC_FRAGMENT;
                else if (mode_next == MODE_AGG)
                    job_next.outcome = OC_AGGREGATE;
                else
                    job_next.outcome = OC_SINGLE;
                mode_next = MODE_IDLE;
            end
        end
        else if (empty_pkt)
            job_next.out_len = '0;
    end

    // current result item out of the job register
    logic [39:0] item_data;
    logic        item_user;
    logic        item_last;

    always_comb
    begin
        item_data = '0;
        item_user = KIND_DATA;
        item_last = (idx_reg == job_total - IDX_W'(1));
        if (idx_reg < job_reg.n_data)
        begin
            if (job_reg.start_code)
                item_data[7:0] = (idx_reg == job_reg.n_data - IDX_W'(1)) ? 8'h01 : 8'h00;
            else
                item_data[7:0] = job_reg.data_byte;
        end
        else
        begin
            item_user          = KIND_SUMMARY;
            item_data[10:8]    = job_reg.outcome;
            item_data[11]      = job_reg.keyframe;
            item_data[12]      = job_reg.frag_start;
            item_data[13]      = job_reg.frag_end;
            item_data[21:14]   = job_reg.header;
            item_data[38:22]   = job_reg.out_len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_rem_reg <= '0;
            mode_reg      <= MODE_IDLE;
            phase_reg     <= PH_LEN_HI;
            len_hi_reg    <= '0;
            nal_left_reg  <= '0;
            nal_first_reg <= 1'b0;
            hdr_idx_reg   <= '0;
            key_reg       <= 1'b0;
            sflag_reg     <= 1'b0;
            eflag_reg     <= 1'b0;
            header_reg    <= '0;
            len_cnt_reg   <= '0;
            err_reg       <= OC_NONE;
            job_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                bytes_rem_reg <= bytes_rem_next;
                mode_reg      <= mode_next;
                phase_reg     <= phase_next;
                len_hi_reg    <= len_hi_next;
                nal_left_reg  <= nal_left_next;
                nal_first_reg <= nal_first_next;
                hdr_idx_reg   <= hdr_idx_next;
                key_reg       <= key_next;
                sflag_reg     <= sflag_next;
                eflag_reg     <= eflag_next;
                header_reg    <= header_next;
                len_cnt_reg   <= len_cnt_next;
                err_reg       <= err_next;
            end

            // a byte with no results leaves the job register empty
            if (in_acc)
            begin
                job_valid_reg <= (job_next.n_data != '0) || job_next.has_sum;
                idx_reg       <= '0;
            end
            else if (job_done)
                job_valid_reg <= 1'b0;
            else if (job_valid_reg && out_load)
                idx_reg <= idx_reg + IDX_W'(1);

            if (out_load)
                out_valid_reg <= job_valid_reg;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_acc)
            job_reg <= job_next;
        if (out_load && job_valid_reg)
        begin
            out_data_reg <= item_data;
            out_user_reg <= item_user;
            out_last_reg <= item_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

    // a summary is always the last result of its byte
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("summary transfer without tlast");

    // pending results block the input
    assert property (@(posedge clk) disable iff (!rst_n)
        job_valid_reg && !job_done |-> !s_axis_tready)
        else $error("input ready while job results pending");

    // the item index stays inside the job
    assert property (@(posedge clk) disable iff (!rst_n)
        job_valid_reg |-> idx_reg < job_total)
        else $error("job item index out of range");

endmodule
